/* hdl/approximate_bitap_matcher_defines.svh */
// Assertion macros for the approximate bitap matcher.
// No dependencies; included by files that carry concurrent checks.
`ifndef APPROXIMATE_BITAP_MATCHER_DEFINES_SVH
`define APPROXIMATE_BITAP_MATCHER_DEFINES_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define BAM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bam check failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define BAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bam check failed: next-cycle implication");
`else
`define BAM_ASSERT_SAME(label, clk, rst, ante, cons)
`define BAM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/bam_pkg.sv */
// Shared types and constants for the approximate bitap matcher.
// No dependencies; imported by every module of the block but bam_ram.
package bam_pkg;

   localparam int ALPHA_ENTRIES = 256;
   localparam int ALPHA_AW      = 8;
   localparam int CHAR_W        = 16;
   localparam int PIDX_W        = 6;
   localparam int LEN_W         = 6;
   localparam int ERR_W         = 4;
   localparam int POS_W         = 32;
   localparam int START_W       = 33;
   localparam int REQ_DATA_W    = 24;
   localparam int REQ_USER_W    = 3;
   localparam int RSP_DATA_W    = 40;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_TEXT  = 2'd2
   } bam_cmd_type;

   // register select is paddr bit 2
   localparam logic CSR_SEL_PATTERN_LENGTH = 1'b0;
   localparam logic CSR_SEL_MAX_ERRORS     = 1'b1;

   typedef struct packed {
      logic                clear;
      logic                load;
      logic [ALPHA_AW-1:0] addr;
      logic [PIDX_W-1:0]   index;
   } bam_tbl_op_type;

   typedef struct packed {
      logic advance;
      logic first;
   } bam_row_ctl_type;

endpackage

/* hdl/bam_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; a read of the address being written returns the old data.
module bam_ram #(
   parameter int WIDTH = 63,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/bam_mask_table.sv */
// Character mask table: RAM with per-entry valid bits and write forwarding.
// Depends on bam_pkg and bam_ram. Invalid entries read as all ones.
module bam_mask_table
   import bam_pkg::*;
#(
   parameter int PATTERN_BITS = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    lookup_en,
   input  logic [ALPHA_AW-1:0]     lookup_addr,
   input  bam_tbl_op_type          op,
   output logic [PATTERN_BITS-1:0] mask
);
   localparam logic [PATTERN_BITS-1:0] ONES = {PATTERN_BITS{1'b1}};

   logic [ALPHA_ENTRIES-1:0] valid_ff, valid_in;
   logic [ALPHA_AW-1:0]      addr_ff;
   logic                     fwd_ff;
   logic [PATTERN_BITS-1:0]  fwd_data_ff;
   logic [PATTERN_BITS-1:0]  ram_q;
   logic                     wr_en;
   logic [PATTERN_BITS-1:0]  wr_data;

   always_comb begin
      if (fwd_ff) begin
         mask = fwd_data_ff;
      end else if (valid_ff[addr_ff]) begin
         mask = ram_q;
      end else begin
         mask = ONES;
      end
   end

   // drop loads beyond the pattern width
   assign wr_en   = op.load && ({1'b0, op.index} < 7'(PATTERN_BITS));
   assign wr_data = mask & ~(PATTERN_BITS'(1) << op.index);

   always_comb begin
      valid_in = valid_ff;
      if (op.clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[op.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // forward a write that lands while the same entry is being read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (lookup_en) begin
         fwd_ff <= wr_en && (op.addr == lookup_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_en) begin
         addr_ff     <= lookup_addr;
         fwd_data_ff <= wr_data;
      end
   end

   bam_ram #(
      .WIDTH(PATTERN_BITS),
      .DEPTH(ALPHA_ENTRIES)
   ) u_mask_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(op.addr),
      .wr_data(wr_data),
      .rd_en  (lookup_en),
      .rd_addr(lookup_addr),
      .rd_data(ram_q)
   );
endmodule

/* hdl/bam_row_engine.sv */
// Error-row state and the shift-and-AND cascade over all error levels.
// Depends on bam_pkg. Reports whether the selected row hits the match bit.
module bam_row_engine
   import bam_pkg::*;
#(
   parameter int PATTERN_BITS     = 63,
   parameter int MAX_ERROR_LEVELS = 8,
   localparam int KW              = $clog2(MAX_ERROR_LEVELS + 2)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bam_row_ctl_type         ctl,
   input  logic [PATTERN_BITS-1:0] mask,
   input  logic [LEN_W-1:0]        len_eff,
   input  logic [KW-1:0]           k_eff,
   output logic                    hit
);
   localparam int ROWS = MAX_ERROR_LEVELS + 1;
   localparam logic [PATTERN_BITS-1:0] ONES = {PATTERN_BITS{1'b1}};

   logic [PATTERN_BITS-1:0] rows_ff   [ROWS];
   logic [PATTERN_BITS-1:0] rows_init [ROWS];
   logic [PATTERN_BITS-1:0] rows_base [ROWS];
   logic [PATTERN_BITS-1:0] rows_in   [ROWS];
   logic [PATTERN_BITS-1:0] row_sel;
   logic [PATTERN_BITS-1:0] match_bit;

   always_comb begin
      for (int d = 0; d < ROWS; d++) begin
         rows_init[d] = ONES << d;
         rows_base[d] = ctl.first ? rows_init[d] : rows_ff[d];
      end
      // 0 = active; row d builds on the old and new row d-1
      rows_in[0] = (rows_base[0] << 1) | mask;
      for (int d = 1; d < ROWS; d++) begin
         rows_in[d] = ((rows_base[d] << 1) | mask)
                    & (rows_base[d-1] << 1)
                    & rows_base[d-1]
                    & (rows_in[d-1] << 1);
      end
   end

   always_comb begin
      row_sel = ONES;
      for (int d = 0; d < ROWS; d++) begin
         if (k_eff == KW'(d)) begin
            row_sel = rows_in[d];
         end
      end
      match_bit = PATTERN_BITS'(1) << (len_eff - LEN_W'(1));
      hit       = |(~row_sel & match_bit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < ROWS; d++) begin
            rows_ff[d] <= ONES << d;
         end
      end else if (ctl.advance) begin
         for (int d = 0; d < ROWS; d++) begin
            rows_ff[d] <= rows_in[d];
         end
      end
   end
endmodule

/* hdl/approximate_bitap_matcher.sv */
// Channel   Dir  Handshake              Payload
// req_      in   tvalid/tready          tdata: char_code, pattern_index; tuser: command, first
// rsp_      out  tvalid/tready          tdata: match_start (signed, 33 bits)
// csr_      in   psel/penable/pready    pattern_length @0x0, max_errors @0x4
//
// One word per cycle unless a match stalls; stage 1 registers feed the output register.
// Stage 0 reads the mask RAM, stage 1 forms the mask and runs the row cascade.
// Mask valid bits and error rows clear in the reset cycle; no sweep is needed.
// A stalled result holds stage 1 only when stage 1 also holds a match.
// Depends on bam_pkg, bam_mask_table, bam_row_engine and the defines header.
`include "approximate_bitap_matcher_defines.svh"
module approximate_bitap_matcher
   import bam_pkg::*;
#(
   parameter int PATTERN_BITS     = 63,
   parameter int MAX_ERROR_LEVELS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] char_code, [21:16] pattern_index, [23:22] zero
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command, [2] first_of_text
   input  logic [REQ_USER_W-1:0]  req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [32:0] match_start, [39:33] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);
   localparam int KW = $clog2(MAX_ERROR_LEVELS + 2);

   logic [LEN_W-1:0]        pattern_length_ff;
   logic [ERR_W-1:0]        max_errors_ff;
   logic                    csr_wr;
   logic [LEN_W-1:0]        len_eff;
   logic [6:0]              k_wide;
   logic [KW-1:0]           k_eff;

   logic                    s1_valid_ff;
   bam_cmd_type             s1_cmd_ff;
   logic [ALPHA_AW-1:0]     s1_char_ff;
   logic [PIDX_W-1:0]       s1_index_ff;
   logic                    s1_first_ff;
   logic                    s1_text;
   logic                    s1_hit;
   logic                    s1_go;
   logic                    commit;
   logic                    accept;
   logic                    out_free;
   logic                    row_hit;

   logic [POS_W-1:0]        pos_ff;
   logic [POS_W-1:0]        cur_pos;
   logic [START_W-1:0]      start;
   logic                    rsp_valid_ff;
   logic [START_W-1:0]      rsp_start_ff;

   logic [PATTERN_BITS-1:0] mask;
   bam_tbl_op_type          tbl_op;
   bam_row_ctl_type         row_ctl;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_W'(1);
         max_errors_ff     <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_SEL_PATTERN_LENGTH) begin
            pattern_length_ff <= csr_pwdata[LEN_W-1:0];
         end else begin
            max_errors_ff <= csr_pwdata[ERR_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_SEL_MAX_ERRORS) begin
         csr_prdata = {{(CSR_DATA_W-ERR_W){1'b0}}, max_errors_ff};
      end else begin
         csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, pattern_length_ff};
      end
   end

   // clamp length to 1..PATTERN_BITS, errors to length and MAX_ERROR_LEVELS
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if ({1'b0, pattern_length_ff} > 7'(PATTERN_BITS)) begin
         len_eff = LEN_W'(PATTERN_BITS);
      end else begin
         len_eff = pattern_length_ff;
      end
      k_wide = {3'b0, max_errors_ff};
      if (k_wide > {1'b0, len_eff}) begin
         k_wide = {1'b0, len_eff};
      end
      if (k_wide > 7'(MAX_ERROR_LEVELS)) begin
         k_wide = 7'(MAX_ERROR_LEVELS);
      end
      k_eff = k_wide[KW-1:0];
   end

   // pipeline control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_text    = s1_valid_ff && (s1_cmd_ff == CMD_TEXT);
   assign s1_hit     = s1_text && row_hit;
   assign s1_go      = !s1_hit || out_free;
   assign commit     = s1_valid_ff && s1_go;
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= bam_cmd_type'(req_tuser[1:0]);
         s1_first_ff <= req_tuser[2];
         s1_char_ff  <= req_tdata[ALPHA_AW-1:0];
         s1_index_ff <= req_tdata[CHAR_W +: PIDX_W];
      end
   end

   always_comb begin
      tbl_op.clear = 1'b0;
      tbl_op.load  = 1'b0;
      tbl_op.addr  = s1_char_ff;
      tbl_op.index = s1_index_ff;
      row_ctl.advance = 1'b0;
      row_ctl.first   = s1_first_ff;
      if (commit) begin
         case (s1_cmd_ff)
            CMD_CLEAR: tbl_op.clear    = 1'b1;
            CMD_LOAD:  tbl_op.load     = 1'b1;
            CMD_TEXT:  row_ctl.advance = 1'b1;
            default:   tbl_op.clear    = 1'b0;
         endcase
      end
   end

   bam_mask_table #(
      .PATTERN_BITS(PATTERN_BITS)
   ) u_mask_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_en  (accept),
      .lookup_addr(req_tdata[ALPHA_AW-1:0]),
      .op         (tbl_op),
      .mask       (mask)
   );

   bam_row_engine #(
      .PATTERN_BITS    (PATTERN_BITS),
      .MAX_ERROR_LEVELS(MAX_ERROR_LEVELS)
   ) u_row_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (row_ctl),
      .mask   (mask),
      .len_eff(len_eff),
      .k_eff  (k_eff),
      .hit    (row_hit)
   );

   // text position and match start
   assign cur_pos = s1_first_ff ? '0 : pos_ff;
   assign start   = {1'b0, cur_pos} - START_W'(len_eff) + START_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (row_ctl.advance) begin
         pos_ff <= cur_pos + POS_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_hit) begin
         rsp_start_ff <= start;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-START_W){1'b0}}, rsp_start_ff};

   `BAM_ASSERT_NEXT(a_rsp_from_text, clock, reset, !rsp_valid_ff && s1_hit, rsp_valid_ff)
   `BAM_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_char_ff) && $stable(pos_ff))
   `BAM_ASSERT_SAME(a_k_le_len, clock, reset, s1_text, {1'b0, k_wide} <= {2'b0, len_eff})
   `BAM_ASSERT_SAME(a_no_accept_on_hold, clock, reset, s1_hit && !out_free, !req_tready)
endmodule
